>>> src/assert_macros.svh
// Assertion macros used by the RTL of the hash unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of aclk outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on the rising edge of aclk outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> src/sha256_pkg.sv
// SHA-256 constants and round functions for the message hash unit.
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t PAD_MARKER = 32'h80000000;

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

    function automatic word_t round_const(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h00000000;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> src/sha256_message_hash_unit.sv
// SHA-256 message hash unit: word intake, padding, round engine and digest output.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Ports
// s_        in         s_valid s_ready s_data_word[31:0] s_byte_count[2:0] s_final_word
// m_        out        m_valid m_ready m_digest_word[31:0] m_word_index[2:0] m_last_of_digest
//
// A non-final word is stored in the schedule memory as it is taken; the word that fills a
// 16-word chunk starts a compression (S_LOAD primes the schedule memory read, S_ROUND runs
// 64 rounds at one round per cycle, S_UPDATE folds the round variables into the hash).
// A final word is followed by its padding words and one or two chunk compressions, then
// eight digest words at one per cycle while m_ready is high; s_ready is low meanwhile.
// Synchronous active-low reset loads the initial hash and clears length and counters.
module sha256_message_hash_unit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire sha256_pkg::word_t    s_data_word,
    input  wire logic [2:0]           s_byte_count,
    input  wire logic                 s_final_word,
    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      sha256_pkg::word_t    m_digest_word,
    output      logic [2:0]           m_word_index,
    output      logic                 m_last_of_digest
);
    import sha256_pkg::*;

    // Control states.
    localparam logic [2:0] S_IDLE   = 3'd0;  // take message words
    localparam logic [2:0] S_PAD    = 3'd1;  // push padding and length words
    localparam logic [2:0] S_LOAD   = 3'd2;  // copy hash into round variables, prime reads
    localparam logic [2:0] S_ROUND  = 3'd3;  // one compression round per cycle
    localparam logic [2:0] S_UPDATE = 3'd4;  // fold round variables into the hash
    localparam logic [2:0] S_OUT    = 3'd5;  // hand out the eight digest words

    // Padding phases.
    localparam logic [1:0] PH_DATA  = 2'd0;  // last data word, masked and marked unless full
    localparam logic [1:0] PH_MARK  = 2'd1;  // standalone marker word after a full last word
    localparam logic [1:0] PH_FILL  = 2'd2;  // zero fill, then length high word
    localparam logic [1:0] PH_LENLO = 2'd3;  // length low word, closes the last chunk

    // Two copies of the 16-word schedule, written together, each with two read ports,
    // give the four schedule taps a round needs in the same cycle.
    word_t sched_a_mem [16];
    word_t sched_b_mem [16];

    logic [2:0]  state_reg,     state_next;
    logic [1:0]  phase_reg,     phase_next;
    logic [3:0]  fill_reg,      fill_next;
    logic [5:0]  round_reg,     round_next;
    logic [63:0] bitlen_reg,    bitlen_next;
    logic [2:0]  count_reg,     count_next;
    logic [2:0]  out_idx_reg,   out_idx_next;
    logic        padding_reg,   padding_next;
    logic        last_blk_reg,  last_blk_next;
    word_t       data_reg,      data_next;
    word_t       hash_reg [8];
    word_t       hash_next [8];
    word_t       work_reg [8];
    word_t       work_next [8];

    // Registered schedule taps for the round in flight.
    word_t       tap16_reg, tap15_reg, tap2_reg, tap7_reg;

    logic        mem_we;
    logic [3:0]  mem_waddr;
    word_t       mem_wdata;
    logic [5:0]  rd_round;
    logic [3:0]  rd_addr16, rd_addr15, rd_addr2, rd_addr7;

    logic        push;
    word_t       push_word;
    logic [2:0]  count_clamped;
    word_t       sched_w, t1, t2;

    // Read addresses follow the round that consumes the registered data in the next cycle.
    always_comb begin
        rd_round  = (state_reg == S_ROUND) ? round_reg + 6'd1 : 6'd0;
        rd_addr16 = rd_round[3:0];
        rd_addr15 = rd_round[3:0] + 4'd1;
        rd_addr2  = rd_round[3:0] - 4'd2;
        rd_addr7  = rd_round[3:0] + 4'd9;
    end

    // Round datapath.
    always_comb begin
        if (round_reg[5:4] == 2'b00) begin
            sched_w = tap16_reg;
        end else begin
            sched_w = small_sigma1(tap2_reg) + tap7_reg + small_sigma0(tap15_reg) + tap16_reg;
        end
        t1 = work_reg[7] + big_sigma1(work_reg[4]) + choose(work_reg[4], work_reg[5], work_reg[6])
             + round_const(round_reg) + sched_w;
        t2 = big_sigma0(work_reg[0]) + majority(work_reg[0], work_reg[1], work_reg[2]);
    end

    assign count_clamped = (s_byte_count > 3'd4) ? 3'd4 : s_byte_count;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        fill_next     = fill_reg;
        round_next    = round_reg;
        bitlen_next   = bitlen_reg;
        count_next    = count_reg;
        out_idx_next  = out_idx_reg;
        padding_next  = padding_reg;
        last_blk_next = last_blk_reg;
        data_next     = data_reg;
        hash_next     = hash_reg;
        work_next     = work_reg;
        push          = 1'b0;
        push_word     = '0;
        mem_we        = 1'b0;
        mem_waddr     = fill_reg;
        mem_wdata     = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (!s_final_word) begin
                        push        = 1'b1;
                        push_word   = s_data_word;
                        bitlen_next = bitlen_reg + 64'd32;
                    end else begin
                        data_next    = s_data_word;
                        count_next   = count_clamped;
                        bitlen_next  = bitlen_reg + {58'd0, count_clamped, 3'b000};
                        padding_next = 1'b1;
                        phase_next   = PH_DATA;
                        state_next   = S_PAD;
                    end
                end
            end
            S_PAD: begin
                push = 1'b1;
                case (phase_reg)
                    PH_DATA: begin
                        phase_next = PH_FILL;
                        case (count_reg)
                            3'd1:    push_word = {data_reg[31:24], 24'h800000};
                            3'd2:    push_word = {data_reg[31:16], 16'h8000};
                            3'd3:    push_word = {data_reg[31:8], 8'h80};
                            3'd4: begin
                                push_word  = data_reg;
                                phase_next = PH_MARK;
                            end
                            default: push_word = PAD_MARKER;
                        endcase
                    end
                    PH_MARK: begin
                        push_word  = PAD_MARKER;
                        phase_next = PH_FILL;
                    end
                    PH_FILL: begin
                        if (fill_reg == 4'd14) begin
                            push_word  = bitlen_reg[63:32];
                            phase_next = PH_LENLO;
                        end else begin
                            push_word = '0;
                        end
                    end
                    default: begin
                        // Low length word always lands in the last slot.
                        push_word     = bitlen_reg[31:0];
                        last_blk_next = 1'b1;
                    end
                endcase
            end
            S_LOAD: begin
                work_next  = hash_reg;
                round_next = 6'd0;
                state_next = S_ROUND;
            end
            S_ROUND: begin
                if (round_reg[5:4] != 2'b00) begin
                    mem_we    = 1'b1;
                    mem_waddr = round_reg[3:0];
                    mem_wdata = sched_w;
                end
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                for (int i = 0; i < 8; i++) begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                out_idx_next = 3'd0;
                if (last_blk_reg) begin
                    state_next = S_OUT;
                end else if (padding_reg) begin
                    state_next = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7) begin
                        // Drop back to the reset state for the next message.
                        hash_next     = INIT_HASH;
                        bitlen_next   = '0;
                        fill_next     = 4'd0;
                        padding_next  = 1'b0;
                        last_blk_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A push stores one chunk word; the sixteenth starts a compression.
        if (push) begin
            mem_we    = 1'b1;
            mem_waddr = fill_reg;
            mem_wdata = push_word;
            fill_next = fill_reg + 4'd1;
            if (fill_reg == 4'd15) begin
                state_next = S_LOAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_DATA;
            fill_reg     <= 4'd0;
            round_reg    <= 6'd0;
            bitlen_reg   <= '0;
            count_reg    <= 3'd0;
            out_idx_reg  <= 3'd0;
            padding_reg  <= 1'b0;
            last_blk_reg <= 1'b0;
            hash_reg     <= INIT_HASH;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            round_reg    <= round_next;
            bitlen_reg   <= bitlen_next;
            count_reg    <= count_next;
            out_idx_reg  <= out_idx_next;
            padding_reg  <= padding_next;
            last_blk_reg <= last_blk_next;
            hash_reg     <= hash_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        work_reg <= work_next;
    end

    // Schedule memories: one write port shared by intake and rounds, registered reads.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sched_a_mem[mem_waddr] <= mem_wdata;
            sched_b_mem[mem_waddr] <= mem_wdata;
        end
        tap16_reg <= sched_a_mem[rd_addr16];
        tap15_reg <= sched_a_mem[rd_addr15];
        tap2_reg  <= sched_b_mem[rd_addr2];
        tap7_reg  <= sched_b_mem[rd_addr7];
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = (state_reg == S_OUT);
    assign m_digest_word    = hash_reg[out_idx_reg];
    assign m_word_index     = out_idx_reg;
    assign m_last_of_digest = (out_idx_reg == 3'd7);

    // Intake and digest output never run together.
    `ASSERT_IMPLIES(a_no_overlap, m_valid, !s_ready)
    // The last round is always followed by the hash update.
    `ASSERT_NEXT(a_round_end, state_reg == S_ROUND && round_reg == 6'd63, state_reg == S_UPDATE)
    // A round's schedule write never hits an address read for the next round.
    `ASSERT_IMPLIES(a_sched_no_collide, state_reg == S_ROUND && mem_we, mem_waddr != rd_addr16 && mem_waddr != rd_addr15 && mem_waddr != rd_addr2 && mem_waddr != rd_addr7)
    // Compression starts only on a full chunk.
    `ASSERT_IMPLIES(a_load_full_chunk, state_reg == S_LOAD, fill_reg == 4'd0)

endmodule

`default_nettype wire

>>> tb/tb_sha256_message_hash_unit.sv
// Testbench for the SHA-256 message hash unit: directed and random word streams checked against a digest predictor.
`timescale 1ns / 1ps

module tb_sha256_message_hash_unit;

    import sha256_pkg::word_t;

    localparam int IDLE_PCT     = 17;      // percent of cycles each side holds off
    localparam int RANDOM_WORDS = 450;     // stop generating messages past this many words
    localparam int DRAIN_CYCLES = 200;     // watch for stray digest words after the last one
    localparam int CYCLE_LIMIT  = 400000;  // far beyond the slowest legal run

    // Standard SHA-256 starting hash and round constants, kept locally for the predictor.
    localparam word_t START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t END_MARKER = 32'h80000000;

    // One message word as presented on the input channel.
    typedef struct packed {
        word_t      data;
        logic [2:0] count;
        logic       is_final;
    } msg_word_t;

    // One digest word as expected on the output channel.
    typedef struct packed {
        word_t      value;
        logic [2:0] index;
        logic       is_last;
    } digest_entry_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;

    logic       s_valid      = 1'b0;
    logic       s_ready;
    word_t      s_data_word  = '0;
    logic [2:0] s_byte_count = '0;
    logic       s_final_word = 1'b0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    word_t      m_digest_word;
    logic [2:0] m_word_index;
    logic       m_last_of_digest;

    msg_word_t     pending_words [$];
    digest_entry_t digest_due [$];
    msg_word_t     next_word;

    // Predictor state: running hash, partly filled chunk, message length in bits.
    word_t       hash_state [8];
    word_t       chunk_buf [16];
    int          chunk_fill;
    logic [63:0] msg_bits;

    int words_taken  = 0;
    int error_count  = 0;
    int cycle_count  = 0;
    logic quiet_stretch;

    sha256_message_hash_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_byte_count     (s_byte_count),
        .s_final_word     (s_final_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_digest_word    (m_digest_word),
        .m_word_index     (m_word_index),
        .m_last_of_digest (m_last_of_digest)
    );

    always #5 aclk = ~aclk;

    // Stretch of the run where neither side holds off, so back-to-back words
    // and back-to-back digest reads both get exercised.
    assign quiet_stretch = (words_taken >= 180) && (words_taken < 300);

    //------------------------------------------------------------------
    // Digest predictor
    //------------------------------------------------------------------

    function automatic word_t ror32(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Clear back to the state of a fresh message.
    function automatic void restart_digest();
        for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
        chunk_fill = 0;
        msg_bits   = '0;
    endfunction

    // Run 64 rounds over the held chunk and fold the result into the hash.
    function automatic void compress_chunk();
        word_t w [64];
        word_t v [8];
        word_t s0, s1, t1, t2;
        for (int r = 0; r < 16; r++) w[r] = chunk_buf[r];
        for (int r = 16; r < 64; r++) begin
            s0   = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
            s1   = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = w[r-16] + s0 + w[r-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
    endfunction

    function automatic void load_chunk_word(input word_t w);
        chunk_buf[chunk_fill] = w;
        chunk_fill++;
        if (chunk_fill == 16) begin
            chunk_fill = 0;
            compress_chunk();
        end
    endfunction

    // Take one accepted word; on the final word pad, close and queue the digest.
    function automatic void hash_message_word(input word_t data, input logic [2:0] count,
                                              input logic is_final);
        int    n;
        word_t keep;
        if (!is_final) begin
            load_chunk_word(data);
            msg_bits += 64'd32;
        end else begin
            n = (count > 3'd4) ? 4 : int'(count);
            msg_bits += 64'(8 * n);
            if (n == 4) begin
                load_chunk_word(data);
                load_chunk_word(END_MARKER);
            end else begin
                keep = (n == 0) ? '0 : (32'hffffffff << (32 - 8 * n));
                load_chunk_word((data & keep) | (32'h80 << (24 - 8 * n)));
            end
            while (chunk_fill != 14) load_chunk_word('0);
            load_chunk_word(msg_bits[63:32]);
            load_chunk_word(msg_bits[31:0]);
            for (int k = 0; k < 8; k++)
                digest_due.push_back('{hash_state[k], 3'(k), k == 7});
            restart_digest();
        end
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    function automatic void queue_word(input word_t data, input logic [2:0] count,
                                       input logic is_final);
        pending_words.push_back('{data, count, is_final});
    endfunction

    // Mostly random data, with all-zero and all-one words mixed in.
    function automatic word_t pick_data();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom;
    endfunction

    //------------------------------------------------------------------
    // Input driver: present queued words, hold each until it is taken,
    // and insert random gaps between words.
    //------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // A word moves at this edge: predict what it leads to.
            if (s_valid && s_ready) begin
                hash_message_word(s_data_word, s_byte_count, s_final_word);
                words_taken <= words_taken + 1;
            end
            // Advance only when the slot is free or being emptied at this edge;
            // otherwise hold valid and payload.
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 &&
                    (quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_word = pending_words.pop_front();
                    s_valid      <= 1'b1;
                    s_data_word  <= next_word.data;
                    s_byte_count <= next_word.count;
                    s_final_word <= next_word.is_final;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Output monitor: stall m_ready at random and compare each digest word
    // with the oldest expected one.
    //------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
            if (m_valid && m_ready) begin
                if (digest_due.size() == 0) begin
                    $display("%0t: unexpected digest word: got %h index %0d last %0b",
                             $time, m_digest_word, m_word_index, m_last_of_digest);
                    error_count++;
                end else begin
                    if (m_digest_word !== digest_due[0].value) begin
                        $display("%0t: digest_word mismatch: expected %h actual %h",
                                 $time, digest_due[0].value, m_digest_word);
                        error_count++;
                    end
                    if (m_word_index !== digest_due[0].index) begin
                        $display("%0t: word_index mismatch: expected %0d actual %0d",
                                 $time, digest_due[0].index, m_word_index);
                        error_count++;
                    end
                    if (m_last_of_digest !== digest_due[0].is_last) begin
                        $display("%0t: last_of_digest mismatch: expected %0b actual %0b",
                                 $time, digest_due[0].is_last, m_last_of_digest);
                        error_count++;
                    end
                    void'(digest_due.pop_front());
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words unsent and %0d digest words outstanding",
                     $time, pending_words.size(), digest_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------
    initial begin
        int total;
        int len;
        int roll;

        restart_digest();

        // Directed messages.
        // Empty message; the data bits must not leak into the hash.
        queue_word(32'hdeadbeef, 3'd0, 1'b1);
        // Three-byte message with junk in the unused low byte.
        queue_word(32'h616263ff, 3'd3, 1'b1);
        // One and two byte messages at the data extremes.
        queue_word(32'hffffffff, 3'd1, 1'b1);
        queue_word(32'h00000000, 3'd2, 1'b1);
        // Full final word, then counts above four that act as four.
        queue_word(32'h12345678, 3'd4, 1'b1);
        queue_word(32'hffffffff, 3'd5, 1'b1);
        queue_word($urandom, 3'd7, 1'b1);
        // Thirteen full words plus a full final word: padding spills into a second chunk.
        // Byte counts on the non-final words are junk and must be ignored.
        for (int i = 0; i < 13; i++)
            queue_word((i % 3 == 0) ? 32'h0 : (i % 3 == 1) ? 32'hffffffff : $urandom,
                       3'(i), 1'b0);
        queue_word($urandom, 3'd6, 1'b1);

        // Random messages, mostly short, a few spanning several chunks.
        total = 0;
        while (total < RANDOM_WORDS) begin
            roll = $urandom_range(0, 99);
            if (roll < 80)      len = $urandom_range(0, 20);
            else if (roll < 95) len = $urandom_range(21, 40);
            else                len = $urandom_range(41, 70);
            for (int i = 0; i < len; i++)
                queue_word(pick_data(), 3'($urandom_range(0, 7)), 1'b0);
            queue_word(pick_data(), 3'($urandom_range(0, 7)), 1'b1);
            total += len + 1;
        end

        // Hold reset while the clock runs, then release.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every word is sent and every digest word has come back.
        while (pending_words.size() != 0 || s_valid || digest_due.size() != 0)
            @(posedge aclk);

        // Keep watching for digest words nobody asked for.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
